@@ rtl/lrfw_pkg.sv @@
package lrfw_pkg;

  localparam int FIFO_DEPTH = 4096;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = FIFO_AW + 1;
  localparam int SMP_W      = 16;
  localparam int STEP_W     = 28;
  localparam int WARM_W     = 4;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_REQ     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Register index as seen on paddr[2].
  localparam logic CFG_IDX_STEP = 1'b0;
  localparam logic CFG_IDX_WARM = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 28'd3855059;
  localparam logic [WARM_W-1:0] WARM_RESET = 4'd4;
  localparam logic [WARM_W-1:0] BLOCKS_MAX = 4'd15;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_INTERP,
    SEL_HOLD
  } sel_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;
    logic                    block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    push_accepted;
    logic                    warmup_silence;
    logic                    held_value;
    logic [LVL_W-1:0]        fifo_level;
  } out_item_t;

  typedef struct packed {
    sel_t             sel;
    logic             restart;
    logic             push_accepted;
    logic             warmup_silence;
    logic             held_value;
    logic [LVL_W-1:0] fifo_level;
  } s1_ctl_t;

endpackage

@@ rtl/lrfw_ram.sv @@
module lrfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ rtl/lrfw_cfg.sv @@
module lrfw_cfg
  import lrfw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [STEP_W-1:0] phase_step,
  output logic [WARM_W-1:0] silence_blocks
);

  logic [STEP_W-1:0] step_r;
  logic [WARM_W-1:0] warm_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      warm_r <= WARM_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        CFG_IDX_STEP: step_r <= pwdata[STEP_W-1:0];
        CFG_IDX_WARM: warm_r <= pwdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_IDX_STEP: prdata = CFG_DW'(step_r);
      CFG_IDX_WARM: prdata = CFG_DW'(warm_r);
      default:      prdata = '0;
    endcase
  end

  assign phase_step     = step_r;
  assign silence_blocks = warm_r;

endmodule

@@ rtl/lrfw_ctrl.sv @@
module lrfw_ctrl
  import lrfw_pkg::*;
#(
  parameter int FB = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  input  logic [STEP_W-1:0]  phase_step,
  input  logic [WARM_W-1:0]  silence_blocks,
  input  logic               s2_ready,
  output logic               s1_valid,
  output s1_ctl_t            s1_ctl,
  output logic [FB-1:0]      s1_frac,
  output logic               ram_we,
  output logic [FIFO_AW-1:0] ram_waddr,
  output logic [SMP_W-1:0]   ram_wdata,
  output logic               ram_re,
  output logic [FIFO_AW-1:0] ram_raddr_a,
  output logic [FIFO_AW-1:0] ram_raddr_b
);

  localparam int SUM_W = ((FB > STEP_W) ? FB : STEP_W) + 1;
  localparam int POP_W = SUM_W - FB;
  localparam int CMP_W = (POP_W > LVL_W) ? POP_W : LVL_W;

  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [LVL_W-1:0]   cnt_r, cnt_nxt;
  logic [FB-1:0]      frac_r, frac_nxt;
  logic [WARM_W-1:0]  blocks_r, blocks_nxt;
  logic               und_r, und_nxt;
  logic               s1_valid_r;
  s1_ctl_t            s1_r, ctl_nxt;
  logic [FB-1:0]      s1_frac_r;

  logic               s1_load_ok;
  logic               accept;
  logic               latch_now;
  logic [SUM_W-1:0]   step_sum;
  logic [CMP_W-1:0]   pops_ext;
  logic [LVL_W-1:0]   pops_c;
  logic signed [SMP_W:0] pair_sum;

  assign s1_load_ok = !s1_valid_r || s2_ready;
  assign in_ready   = s1_load_ok;
  assign accept     = in_valid && in_ready;

  // Whole samples passed by this step, limited to what is stored.
  assign step_sum = SUM_W'(frac_r) + SUM_W'(phase_step);
  assign pops_ext = CMP_W'(step_sum[SUM_W-1:FB]);
  assign pops_c   = (pops_ext > CMP_W'(cnt_r)) ? cnt_r : pops_ext[LVL_W-1:0];

  // Floor of the average is the sum shifted right with its sign.
  assign pair_sum  = {in_data.left_in[SMP_W-1], in_data.left_in}
                   + {in_data.right_in[SMP_W-1], in_data.right_in};
  assign ram_wdata = pair_sum[SMP_W:1];
  assign ram_waddr = rp_r + cnt_r[FIFO_AW-1:0];

  // Head samples are read on every accepted item; only requests use them.
  assign ram_re      = accept;
  assign ram_raddr_a = rp_r;
  assign ram_raddr_b = rp_r + FIFO_AW'(1);

  always_comb begin
    rp_nxt     = rp_r;
    cnt_nxt    = cnt_r;
    frac_nxt   = frac_r;
    blocks_nxt = blocks_r;
    und_nxt    = und_r;
    ram_we     = 1'b0;
    latch_now  = 1'b0;
    ctl_nxt    = '0;
    ctl_nxt.sel = SEL_ZERO;
    if (accept) begin
      case (in_data.cmd)
        CMD_PUSH: begin
          if (cnt_r < LVL_W'(FIFO_DEPTH)) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + LVL_W'(1);
            ctl_nxt.push_accepted = 1'b1;
          end
        end
        CMD_REQ: begin
          if (blocks_r < silence_blocks) begin
            ctl_nxt.warmup_silence = 1'b1;
          end else begin
            latch_now = und_r || (cnt_r < LVL_W'(2));
            und_nxt   = latch_now;
            if (latch_now) begin
              ctl_nxt.sel        = SEL_HOLD;
              ctl_nxt.held_value = 1'b1;
            end else begin
              ctl_nxt.sel = SEL_INTERP;
              frac_nxt    = step_sum[FB-1:0];
              rp_nxt      = rp_r + pops_c[FIFO_AW-1:0];
              cnt_nxt     = cnt_r - pops_c;
            end
          end
          if (in_data.block_end) begin
            if (blocks_r != BLOCKS_MAX) begin
              blocks_nxt = blocks_r + WARM_W'(1);
            end
            und_nxt = 1'b0;
          end
        end
        CMD_RESTART: begin
          rp_nxt     = '0;
          cnt_nxt    = '0;
          frac_nxt   = '0;
          blocks_nxt = '0;
          und_nxt    = 1'b0;
          ctl_nxt.restart = 1'b1;
        end
        default: ;
      endcase
      ctl_nxt.fifo_level = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r       <= '0;
      cnt_r      <= '0;
      frac_r     <= '0;
      blocks_r   <= '0;
      und_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      rp_r     <= rp_nxt;
      cnt_r    <= cnt_nxt;
      frac_r   <= frac_nxt;
      blocks_r <= blocks_nxt;
      und_r    <= und_nxt;
      if (s1_load_ok) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= ctl_nxt;
      s1_frac_r <= frac_r;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_ctl   = s1_r;
  assign s1_frac  = s1_frac_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LVL_W'(FIFO_DEPTH))
    else $error("FIFO level beyond depth");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.cmd == CMD_RESTART |=> cnt_r == '0 && rp_r == '0 && !und_r)
    else $error("restart left FIFO state behind");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(s1_r) && $stable(s1_frac_r))
    else $error("stalled stage lost its item");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.cmd == CMD_PUSH && cnt_r == LVL_W'(FIFO_DEPTH) |-> !ram_we)
    else $error("push written into a full FIFO");

endmodule

@@ rtl/lrfw_interp.sv @@
module lrfw_interp
  import lrfw_pkg::*;
#(
  parameter int FB = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_valid,
  input  s1_ctl_t          s1_ctl,
  input  logic [FB-1:0]    s1_frac,
  input  logic [SMP_W-1:0] head0,
  input  logic [SMP_W-1:0] head1,
  output logic             s2_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int PROD_W = SMP_W + 1 + FB + 1;

  logic                    out_valid_r;
  out_item_t               out_r, out_nxt;
  logic [SMP_W-1:0]        hold_r;
  logic                    load;
  logic signed [SMP_W:0]   diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic [SMP_W:0]          interp_sum;
  logic [SMP_W-1:0]        interp;

  assign s2_ready = !out_valid_r || out_ready;
  assign load     = s1_valid && s2_ready;

  // s0 + floor((s1 - s0) * frac / 2^FB), exact for the weighted form.
  assign diff       = $signed({head1[SMP_W-1], head1}) - $signed({head0[SMP_W-1], head0});
  assign prod       = diff * $signed({1'b0, s1_frac});
  assign prod_sh    = prod >>> FB;
  assign interp_sum = {head0[SMP_W-1], head0} + prod_sh[SMP_W:0];
  assign interp     = interp_sum[SMP_W-1:0];

  always_comb begin
    out_nxt                = '0;
    out_nxt.push_accepted  = s1_ctl.push_accepted;
    out_nxt.warmup_silence = s1_ctl.warmup_silence;
    out_nxt.held_value     = s1_ctl.held_value;
    out_nxt.fifo_level     = s1_ctl.fifo_level;
    case (s1_ctl.sel)
      SEL_INTERP: out_nxt.sample_out = interp;
      SEL_HOLD:   out_nxt.sample_out = hold_r;
      default:    out_nxt.sample_out = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_r      <= '0;
    end else begin
      if (s2_ready) begin
        out_valid_r <= s1_valid;
      end
      if (load) begin
        if (s1_ctl.restart) begin
          hold_r <= '0;
        end else if (s1_ctl.sel == SEL_INTERP) begin
          hold_r <= interp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/linear_resampler_fifo_warmup.sv @@
// Channel   Ports                                          Direction
// input     in_valid, in_ready, in_data (in_item_t)        item in
// result    out_valid, out_ready, out_data (out_item_t)    item out
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready  register access
//
// One item is accepted per cycle while in_ready is high; its result leaves the second stage.
// The first stage updates the FIFO state and reads both head samples from the
// sample RAM; the second does the interpolation multiply into the output register.
// When the output stalls, the two stages fill and in_ready drops after that.
// Reset clears all FIFO, phase and warm-up state; the sample RAM is not cleared.
module linear_resampler_fifo_warmup
  import lrfw_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [STEP_W-1:0]          phase_step;
  logic [WARM_W-1:0]          silence_blocks;
  logic                       s2_ready;
  logic                       s1_valid;
  s1_ctl_t                    s1_ctl;
  logic [PHASE_FRAC_BITS-1:0] s1_frac;
  logic                       ram_we;
  logic [FIFO_AW-1:0]         ram_waddr;
  logic [SMP_W-1:0]           ram_wdata;
  logic                       ram_re;
  logic [FIFO_AW-1:0]         ram_raddr_a;
  logic [FIFO_AW-1:0]         ram_raddr_b;
  logic [SMP_W-1:0]           head0;
  logic [SMP_W-1:0]           head1;

  lrfw_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .phase_step     (phase_step),
    .silence_blocks (silence_blocks)
  );

  lrfw_ctrl #(
    .FB (PHASE_FRAC_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .phase_step     (phase_step),
    .silence_blocks (silence_blocks),
    .s2_ready       (s2_ready),
    .s1_valid       (s1_valid),
    .s1_ctl         (s1_ctl),
    .s1_frac        (s1_frac),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr_a    (ram_raddr_a),
    .ram_raddr_b    (ram_raddr_b)
  );

  lrfw_ram #(
    .WIDTH (SMP_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (head0),
    .rdata_b (head1)
  );

  lrfw_interp #(
    .FB (PHASE_FRAC_BITS)
  ) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_frac   (s1_frac),
    .head0     (head0),
    .head1     (head1),
    .s2_ready  (s2_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrfw_pkg::*;

  localparam int PHASE_FRAC = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int MAX_PRINTS = 100;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [STEP_W-1:0] STEP_MIN = 28'd1;
  localparam logic [STEP_W-1:0] STEP_MAX = 28'hFFFFFFF;
  localparam logic [STEP_W-1:0] STEP_UNITY = 28'd1 << PHASE_FRAC;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  linear_resampler_fifo_warmup #(
    .PHASE_FRAC_BITS(PHASE_FRAC)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the resampler state and its registers.
  logic [SMP_W-1:0] ring_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] rd_ptr_q = '0;
  int unsigned level_q = 0;
  logic [PHASE_FRAC-1:0] frac_q = '0;
  logic [SMP_W-1:0] hold_q = '0;
  logic [WARM_W-1:0] blocks_q = '0;
  bit underrun_q = 1'b0;
  logic [STEP_W-1:0] step_cfg = STEP_RESET;
  logic [WARM_W-1:0] warm_cfg = WARM_RESET;

  in_item_t stimulus_items [$];
  out_item_t resampler_outputs [$];
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned pushes_refused = 0;
  int unsigned silent_reqs = 0;
  int unsigned held_reqs = 0;
  int unsigned interp_reqs = 0;
  int unsigned over_advances = 0;
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;

  function automatic out_item_t resample_step(in_item_t it);
    out_item_t r;
    int mono;
    longint unsigned u0, u1, f, acc, pops;
    logic [FIFO_AW-1:0] widx;
    r = '0;
    case (it.cmd)
      CMD_PUSH: begin
        if (level_q < FIFO_DEPTH) begin
          // Arithmetic shift floors the average of the pair.
          mono = (int'($signed(it.left_in)) + int'($signed(it.right_in))) >>> 1;
          widx = rd_ptr_q + FIFO_AW'(level_q);
          ring_q[widx] = mono[SMP_W-1:0];
          level_q++;
          r.push_accepted = 1'b1;
        end else begin
          pushes_refused++;
        end
      end
      CMD_REQ: begin
        if (blocks_q < warm_cfg) begin
          r.warmup_silence = 1'b1;
          silent_reqs++;
        end else begin
          if (!underrun_q && level_q < 2) underrun_q = 1'b1;
          if (underrun_q) begin
            r.sample_out = hold_q;
            r.held_value = 1'b1;
            held_reqs++;
          end else begin
            // Offset binary keeps the blend unsigned.
            f = 64'(frac_q);
            u0 = 64'(ring_q[rd_ptr_q] ^ 16'h8000);
            u1 = 64'(ring_q[rd_ptr_q + FIFO_AW'(1)] ^ 16'h8000);
            acc = u0 * ((64'd1 << PHASE_FRAC) - f) + u1 * f;
            hold_q = SMP_W'(acc >> PHASE_FRAC) ^ 16'h8000;
            r.sample_out = hold_q;
            acc = f + 64'(step_cfg);
            pops = acc >> PHASE_FRAC;
            frac_q = acc[PHASE_FRAC-1:0];
            if (pops > level_q) begin
              pops = 64'(level_q);
              over_advances++;
            end
            rd_ptr_q = rd_ptr_q + FIFO_AW'(pops);
            level_q = level_q - int'(pops);
            interp_reqs++;
          end
        end
        if (it.block_end) begin
          if (blocks_q < BLOCKS_MAX) blocks_q++;
          underrun_q = 1'b0;
        end
      end
      CMD_RESTART: begin
        rd_ptr_q = '0;
        level_q = 0;
        frac_q = '0;
        hold_q = '0;
        blocks_q = '0;
        underrun_q = 1'b0;
      end
      default: ;
    endcase
    r.fifo_level = LVL_W'(level_q);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h8000;
    else if (r < 16) return 16'h7FFF;
    else if (r < 20) return 16'hFFFF;
    else if (r < 23) return 16'h0000;
    else return SMP_W'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("ERROR %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Sampling side: register accesses, results, and accepted items.
  always @(posedge clk) begin
    out_item_t want;
    logic [CFG_DW-1:0] reg_value;
    in_fire = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (rst_n && psel && penable && pready) begin
      if (pwrite) begin
        if (paddr[2] == CFG_IDX_STEP) step_cfg = pwdata[STEP_W-1:0];
        else warm_cfg = pwdata[WARM_W-1:0];
      end else begin
        reg_value = (paddr[2] == CFG_IDX_STEP) ? CFG_DW'(step_cfg) : CFG_DW'(warm_cfg);
        if (prdata !== reg_value)
          report_mismatch("register readback", 64'(prdata), 64'(reg_value));
      end
    end
    if (out_fire) begin
      if (resampler_outputs.size() == 0) begin
        report_mismatch("result with no item pending", 64'(out_data), 64'd0);
      end else begin
        want = resampler_outputs.pop_front();
        if (out_data.sample_out !== want.sample_out)
          report_mismatch("sample_out", 64'(out_data.sample_out), 64'(want.sample_out));
        if (out_data.push_accepted !== want.push_accepted)
          report_mismatch("push_accepted", 64'(out_data.push_accepted),
                          64'(want.push_accepted));
        if (out_data.warmup_silence !== want.warmup_silence)
          report_mismatch("warmup_silence", 64'(out_data.warmup_silence),
                          64'(want.warmup_silence));
        if (out_data.held_value !== want.held_value)
          report_mismatch("held_value", 64'(out_data.held_value), 64'(want.held_value));
        if (out_data.fifo_level !== want.fifo_level)
          report_mismatch("fifo_level", 64'(out_data.fifo_level), 64'(want.fifo_level));
        results_checked++;
      end
    end
    if (in_fire) begin
      resampler_outputs.push_back(resample_step(in_data));
      items_accepted++;
    end
  end

  // Sender: offers items from the stimulus queue with random gaps.
  int unsigned tx_gap = 0;
  int unsigned tx_cycles = 0;
  always @(negedge clk) begin
    logic nv;
    in_item_t nd;
    nv = in_valid;
    nd = in_data;
    tx_cycles++;
    if (rst_n) begin
      if (in_fire) begin
        nv = 1'b0;
        tx_gap = ((tx_cycles % 600) < 150) ? 0 : pick_gap();
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (stimulus_items.size() > 0) begin
          nd = stimulus_items.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // Receiver: random stalls, plus one long hold-off while items keep coming.
  int unsigned rx_gap = 0;
  int unsigned rx_cycles = 0;
  int unsigned hold_off_left = 0;
  bit hold_off_done = 1'b0;
  always @(negedge clk) begin
    rx_cycles++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else if (!hold_off_done && results_checked >= 600 && stimulus_items.size() > 50) begin
      hold_off_done = 1'b1;
      hold_off_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ((rx_cycles % 700) >= 200 && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
    end
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles = 0;
    else if (rst_n) quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("linear_resampler_fifo_warmup regression: fail");
      $finish;
    end
  end

  task automatic queue_item(logic [1:0] cmd, logic [SMP_W-1:0] l, logic [SMP_W-1:0] r,
                            logic be);
    in_item_t it;
    it.cmd = cmd;
    it.left_in = l;
    it.right_in = r;
    it.block_end = be;
    stimulus_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_accepted != items_queued || resampler_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_access(logic idx, logic wr, logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [STEP_W-1:0] step, logic [WARM_W-1:0] warm);
    logic [CFG_DW-1:0] v;
    wait_idle();
    // Upper bits beyond the register width are sometimes set and must be dropped.
    v = $urandom_range(0, 1) ? $urandom() : '0;
    v[STEP_W-1:0] = step;
    reg_access(CFG_IDX_STEP, 1'b1, v);
    v = $urandom_range(0, 1) ? $urandom() : '0;
    v[WARM_W-1:0] = warm;
    reg_access(CFG_IDX_WARM, 1'b1, v);
    reg_access(CFG_IDX_STEP, 1'b0, '0);
    reg_access(CFG_IDX_WARM, 1'b0, '0);
    @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned made, burst, k, pick;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Pushes followed by a run of one to burst+4 requests, blocks ended at random.
        burst = $urandom_range(1, 24);
        repeat (burst) queue_item(CMD_PUSH, rand_sample(), rand_sample(),
                                  1'($urandom_range(0, 1)));
        k = $urandom_range(1, burst + 4);
        repeat (k) queue_item(CMD_REQ, rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
        made += burst + k;
      end else if (pick < 82) begin
        k = $urandom_range(1, 6);
        repeat (k) queue_item(CMD_REQ, rand_sample(), rand_sample(), $urandom_range(0, 3) == 0);
        made += k;
      end else if (pick < 86) begin
        queue_item(CMD_RESTART, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
        made++;
      end else if (pick < 89) begin
        queue_item(CMD_UNUSED, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        queue_item(2'($urandom_range(0, 2)), rand_sample(), rand_sample(),
                   1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    reg_access(CFG_IDX_STEP, 1'b0, '0);
    reg_access(CFG_IDX_WARM, 1'b0, '0);
    @(posedge clk);

    // Directed: warm-up silence, underrun before any sample, averaging extremes,
    // interpolation, the unused command and restart.
    queue_item(CMD_REQ, 16'h0000, 16'h0000, 1'b0);
    repeat (4) queue_item(CMD_REQ, 16'hFFFF, 16'h8000, 1'b1);
    queue_item(CMD_REQ, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_item(CMD_REQ, 16'h0000, 16'h0000, 1'b1);
    queue_item(CMD_PUSH, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_item(CMD_PUSH, 16'h8000, 16'h8000, 1'b1);
    queue_item(CMD_PUSH, 16'h8000, 16'h7FFF, 1'b0);
    queue_item(CMD_PUSH, 16'hFFFF, 16'h0000, 1'b0);
    queue_item(CMD_PUSH, 16'h0001, 16'hFFFE, 1'b0);
    queue_item(CMD_PUSH, 16'h7FFF, 16'h8000, 1'b0);
    queue_item(CMD_PUSH, 16'h0000, 16'h0001, 1'b0);
    repeat (3) queue_item(CMD_REQ, 16'h5555, 16'hAAAA, 1'b0);
    queue_item(CMD_UNUSED, 16'h1234, 16'hFEDC, 1'b1);
    queue_item(CMD_REQ, 16'h0000, 16'h0000, 1'b1);
    queue_item(CMD_RESTART, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_item(CMD_REQ, 16'h0000, 16'h0000, 1'b0);

    set_config(STEP_MIN, 4'd0);
    random_traffic(230);
    set_config(STEP_MAX, 4'd15);
    // Seventeen block ends: warm-up finishes and the block count saturates.
    repeat (17) queue_item(CMD_REQ, rand_sample(), rand_sample(), 1'b1);
    random_traffic(230);
    set_config(STEP_UNITY, 4'd0);
    random_traffic(230);
    set_config(STEP_W'($urandom_range(1 << 23, 1 << 25)), WARM_W'($urandom_range(0, 3)));
    random_traffic(230);

    set_config(STEP_W'($urandom_range(1, 28'hFFFFFFF)), WARM_W'($urandom_range(0, 15)));
    random_traffic(230);
    set_config(STEP_W'($urandom_range(1 << 20, 1 << 24)), 4'd1);
    random_traffic(230);
    set_config(STEP_RESET, WARM_RESET);
    random_traffic(230);
    set_config(STEP_W'($urandom_range(1 << 24, 3 << 24)), 4'd2);
    random_traffic(230);

    wait_idle();
    repeat (10) @(negedge clk);
    $display("%0d items checked: %0d interpolated, %0d silent, %0d held requests",
             results_checked, interp_reqs, silent_reqs, held_reqs);
    $display("%0d pushes refused on a full FIFO, %0d over-advanced requests, %0d mismatches",
             pushes_refused, over_advances, mismatches);
    if (mismatches == 0) begin
      $display("linear_resampler_fifo_warmup regression: pass");
    end else begin
      $display("linear_resampler_fifo_warmup regression: fail");
    end
    $finish;
  end

endmodule
